/* design/linear_probe_hash_table_unit_macros.svh */
// Assertion macros for the linear probing hash table unit.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LPHT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linear_probe_hash_table_unit: same-cycle check failed");
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linear_probe_hash_table_unit: next-cycle check failed");
`else
`define LPHT_ASSERT_IMPLIES(lbl, ante, cons)
`define LPHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/lpht_pkg.sv */
// Shared types and codes for the linear probing hash table unit.
// No dependencies; used by lpht_key_chk, the top level, the scoreboard and the bench.
package lpht_pkg;

  localparam int SLOTS = 26;
  localparam int KEY_W = 64;
  localparam int LEN_W = 4;
  localparam int IDX_W = 5;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] ALPHABET     = 8'd26;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [2:0] CODE_OK        = 3'd0;
  localparam logic [2:0] CODE_NOT_FOUND = 3'd1;
  localparam logic [2:0] CODE_PRESENT   = 3'd2;
  localparam logic [2:0] CODE_FULL      = 3'd3;
  localparam logic [2:0] CODE_BAD_KEY   = 3'd4;

  localparam logic [1:0] ST_NEVER = 2'd0;
  localparam logic [1:0] ST_OCC   = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key_text;
    logic [LEN_W-1:0] key_length;
    logic [IDX_W-1:0] slot_index;
  } req_word_t;

  typedef struct packed {
    logic [2:0]       result_code;
    logic [IDX_W-1:0] slot;
    logic [1:0]       slot_state;
    logic [KEY_W-1:0] key_text_out;
    logic [LEN_W-1:0] key_length_out;
  } rsp_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] key_length;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic             bad;
    logic [IDX_W-1:0] home;
    logic [KEY_W-1:0] key;
  } key_info_t;

endpackage

/* design/lpht_key_chk.sv */
// Key qualification: masks the key bytes, checks the length and the last
// character, and derives the home slot. Depends on lpht_pkg.
module lpht_key_chk import lpht_pkg::*; #(
  parameter int KEY_CHARS = 8
) (
  input  logic [KEY_W-1:0] key_text,
  input  logic [LEN_W-1:0] key_length,
  output key_info_t        info
);

  logic [KEY_W-1:0] key_m;
  logic [7:0] last_raw;
  logic [7:0] last_lc;
  logic       len_bad;

  always_comb begin
    key_m = '0;
    last_raw = '0;
    for (int i = 0; i < 8; i++) begin
      if (LEN_W'(i) < key_length) begin
        key_m[8*i +: 8] = key_text[8*i +: 8];
      end
      if (key_length == LEN_W'(i + 1)) begin
        last_raw = key_text[8*i +: 8];
      end
    end
  end

  always_comb begin
    if (last_raw >= CHAR_UPPER_A && last_raw <= CHAR_UPPER_Z) begin
      last_lc = last_raw + CASE_OFFSET;
    end else begin
      last_lc = last_raw;
    end
  end

  assign len_bad = (key_length == '0) || (key_length > LEN_W'(KEY_CHARS));
  assign info    = '{bad:  len_bad || (last_lc < CHAR_LOWER_A)
                           || (last_lc >= CHAR_LOWER_A + ALPHABET),
                     home: IDX_W'(last_lc - CHAR_LOWER_A),
                     key:  key_m};

endmodule

/* design/linear_probe_hash_table_unit.sv */
// Linear probing hash table with tombstones: probe sequencer and slot memory.
// Depends on lpht_pkg, lpht_key_chk and linear_probe_hash_table_unit_macros.svh.
//
// Usage: a request word (command, key, length, slot index) is taken on the
// req channel when req_valid is high and req_stall low; exactly one response
// word leaves on the rsp channel for every request. req_stall is high from
// the cycle after acceptance until the response word enters the output register.
// A bad key or an out-of-range read-slot goes straight to the response step;
// read-slot passes through the start and read steps; insert, delete and
// lookup pass through the start step and then probe p slots, 1 to SLOTS.
// The probe reads one slot per cycle from the slot memory, which has a read
// port and a write port; an insert uses the first free slot of the same pass.
// The response is held in an output register, so a stalled receiver does
// not stop the next request from being accepted; a finished item waits in
// its response step only while the output register is still full.
// Reset clears every slot to never used through per-slot valid
// bits; the key storage itself is not cleared.
`include "linear_probe_hash_table_unit_macros.svh"

module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int KEY_CHARS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMP_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_READ,
    S_RESP
  } state_t;

  state_t           state;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] key;
  logic [LEN_W-1:0] key_len;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] cnt;
  logic             free_found;
  logic [SLOT_W-1:0] free_pos;
  rsp_word_t        res;

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] valid;
  entry_t           rdata;
  logic             rd_valid;
  logic [SLOT_W-1:0] rd_addr;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t           wr_data;

  key_info_t        info;
  logic             idx_oob;
  logic [SLOT_W-1:0] pos_inc;
  logic [1:0]       st_eff;
  logic             is_hit;
  logic             stop_miss;
  logic             free_any;
  logic [SLOT_W-1:0] free_slot;

  lpht_key_chk #(
    .KEY_CHARS(KEY_CHARS)
  ) u_key_chk (
    .key_text  (req.key_text),
    .key_length(req.key_length),
    .info      (info)
  );

  assign req_stall = (state != S_IDLE);
  assign idx_oob   = CMP_W'(req.slot_index) >= CMP_W'(SLOTS);
  assign pos_inc   = (pos == SLOT_W'(SLOTS - 1)) ? '0 : pos + 1'b1;
  assign rd_addr   = (state == S_PROBE) ? pos_inc : pos;

  assign st_eff    = rd_valid ? rdata.status : ST_NEVER;
  assign is_hit    = (st_eff == ST_OCC) && (rdata.key == key) && (rdata.key_length == key_len);
  assign stop_miss = !is_hit && ((st_eff == ST_NEVER) || (cnt == SLOT_W'(SLOTS - 1)));
  assign free_any  = free_found || (st_eff != ST_OCC);
  assign free_slot = free_found ? free_pos : pos;

  always_comb begin
    wr_en = (state == S_PROBE)
            && ((is_hit && cmd == CMD_DELETE)
                || (stop_miss && cmd == CMD_INSERT && free_any));
    wr_addr = is_hit ? pos : free_slot;
    if (is_hit) begin
      wr_data = '{status: ST_TOMB, key_length: rdata.key_length, key: rdata.key};
    end else begin
      wr_data = '{status: ST_OCC, key_length: key_len, key: key};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd        <= req.command;
            key        <= info.key;
            key_len    <= req.key_length;
            cnt        <= '0;
            free_found <= 1'b0;
            if (req.command == CMD_READ) begin
              pos <= SLOT_W'(req.slot_index);
              if (idx_oob) begin
                res   <= '{result_code: CODE_NOT_FOUND, slot: req.slot_index,
                           slot_state: ST_NEVER, key_text_out: '0, key_length_out: '0};
                state <= S_RESP;
              end else begin
                state <= S_START;
              end
            end else begin
              pos <= SLOT_W'(info.home);
              if (info.bad) begin
                res   <= '{result_code: CODE_BAD_KEY, slot: '0,
                           slot_state: ST_NEVER, key_text_out: '0, key_length_out: '0};
                state <= S_RESP;
              end else begin
                state <= S_START;
              end
            end
          end
        end
        S_START: begin
          state <= (cmd == CMD_READ) ? S_READ : S_PROBE;
        end
        S_READ: begin
          res.result_code <= CODE_OK;
          res.slot        <= IDX_W'(pos);
          res.slot_state  <= st_eff;
          if (st_eff != ST_NEVER) begin
            res.key_text_out   <= rdata.key;
            res.key_length_out <= rdata.key_length;
          end else begin
            res.key_text_out   <= '0;
            res.key_length_out <= '0;
          end
          state <= S_RESP;
        end
        S_PROBE: begin
          res.slot_state     <= ST_NEVER;
          res.key_text_out   <= '0;
          res.key_length_out <= '0;
          if (is_hit) begin
            res.result_code <= (cmd == CMD_INSERT) ? CODE_PRESENT : CODE_OK;
            res.slot        <= IDX_W'(pos);
            state           <= S_RESP;
          end else if (stop_miss) begin
            if (cmd == CMD_INSERT && free_any) begin
              res.result_code <= CODE_OK;
              res.slot        <= IDX_W'(free_slot);
            end else begin
              res.result_code <= (cmd == CMD_INSERT) ? CODE_FULL : CODE_NOT_FOUND;
              res.slot        <= '0;
            end
            state <= S_RESP;
          end else begin
            pos <= pos_inc;
            cnt <= cnt + 1'b1;
            if (!free_found && st_eff != ST_OCC) begin
              free_found <= 1'b1;
              free_pos   <= pos;
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LPHT_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state != S_IDLE)
  `LPHT_ASSERT_NEXT(a_write_sets_valid, wr_en, valid[$past(wr_addr)])
  `LPHT_ASSERT_IMPLIES(a_tomb_on_delete_hit, wr_en && wr_data.status == ST_TOMB, is_hit && cmd == CMD_DELETE)

endmodule

/* bench/lpht_scoreboard_pkg.sv */
// Scoreboard for the hash table bench: a private copy of the slot table that
// predicts each response word, and the queue of words still owed by the unit.
// Depends on lpht_pkg for the word types, commands, codes and slot states.
package lpht_scoreboard_pkg;
  import lpht_pkg::*;

  localparam int TABLE_SLOTS   = SLOTS;
  localparam int MAX_KEY_CHARS = 8;

  class table_scoreboard;
    logic [1:0]       slot_status [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_key    [TABLE_SLOTS];
    logic [LEN_W-1:0] slot_len    [TABLE_SLOTS];
    rsp_word_t        owed_words  [$];
    int unsigned      mismatches;

    function new();
      foreach (slot_status[i]) begin
        slot_status[i] = ST_NEVER;
        slot_key[i]    = '0;
        slot_len[i]    = '0;
      end
      mismatches = 0;
    endfunction

    function rsp_word_t apply_command(req_word_t w);
      rsp_word_t        r;
      logic [KEY_W-1:0] key;
      logic [7:0]       last;
      int               pos;
      int               hit;
      int               spot;
      r = '0;
      if (w.command == CMD_READ) begin
        r.slot = w.slot_index;
        if (w.slot_index >= TABLE_SLOTS) begin
          r.result_code = CODE_NOT_FOUND;
        end else begin
          r.slot_state = slot_status[w.slot_index];
          if (slot_status[w.slot_index] != ST_NEVER) begin
            r.key_text_out   = slot_key[w.slot_index];
            r.key_length_out = slot_len[w.slot_index];
          end
        end
        return r;
      end
      if (w.key_length == 0 || w.key_length > MAX_KEY_CHARS) begin
        r.result_code = CODE_BAD_KEY;
        return r;
      end
      key = w.key_text;
      for (int b = int'(w.key_length); b < KEY_W / 8; b++) key[8 * b +: 8] = 8'h00;
      last = key[8 * (int'(w.key_length) - 1) +: 8];
      if (last >= CHAR_UPPER_A && last <= CHAR_UPPER_Z) last = last + CASE_OFFSET;
      if (last < CHAR_LOWER_A || last >= CHAR_LOWER_A + ALPHABET) begin
        r.result_code = CODE_BAD_KEY;
        return r;
      end
      // One pass finds both the key and the first slot that an insert may take.
      pos  = int'(last - CHAR_LOWER_A);
      hit  = -1;
      spot = -1;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (slot_status[pos] == ST_OCC && slot_key[pos] == key &&
            slot_len[pos] == w.key_length) begin
          hit = pos;
          break;
        end
        if (slot_status[pos] != ST_OCC && spot < 0) spot = pos;
        if (slot_status[pos] == ST_NEVER) break;
        pos = (pos + 1) % TABLE_SLOTS;
      end
      if (w.command == CMD_INSERT) begin
        if (hit >= 0) begin
          r.result_code = CODE_PRESENT;
          r.slot        = IDX_W'(hit);
        end else if (spot < 0) begin
          r.result_code = CODE_FULL;
        end else begin
          slot_status[spot] = ST_OCC;
          slot_key[spot]    = key;
          slot_len[spot]    = w.key_length;
          r.slot            = IDX_W'(spot);
        end
      end else if (hit < 0) begin
        r.result_code = CODE_NOT_FOUND;
      end else begin
        if (w.command == CMD_DELETE) slot_status[hit] = ST_TOMB;
        r.slot = IDX_W'(hit);
      end
      return r;
    endfunction

    function void note_request(req_word_t w);
      owed_words.push_back(apply_command(w));
    endfunction

    function void check_result(rsp_word_t got);
      rsp_word_t want;
      bit        orphan;
      bit        wrong;
      orphan = (owed_words.size() == 0);
      want   = '0;
      if (!orphan) want = owed_words.pop_front();
      wrong = orphan ||
              got.result_code    !== want.result_code ||
              got.slot           !== want.slot ||
              got.slot_state     !== want.slot_state ||
              got.key_text_out   !== want.key_text_out ||
              got.key_length_out !== want.key_length_out;
      if (!wrong) return;
      mismatches++;
      if (mismatches > 10) return;
      if (orphan) begin
        $display("%0t: response word arrived with nothing outstanding", $time);
      end else begin
        $display("%0t: response mismatch, expected code %0d slot %0d state %0d key %h len %0d",
                 $time, want.result_code, want.slot, want.slot_state, want.key_text_out,
                 want.key_length_out);
      end
      $display("%0t:                      got code %0d slot %0d state %0d key %h len %0d",
               $time, got.result_code, got.slot, got.slot_state, got.key_text_out,
               got.key_length_out);
    endfunction

    function int unsigned outstanding();
      return owed_words.size();
    endfunction
  endclass

endpackage

/* bench/tb_linear_probe_hash_table_unit.sv */
// Top-level bench for the linear probing hash table unit: directed and random
// request words with random idling on both channels, checked word by word.
// Depends on lpht_pkg, lpht_scoreboard_pkg and the unit itself.
module tb_linear_probe_hash_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;
  import lpht_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEM_TARGET  = 1950;
  localparam int DRAIN_CYCLES = 64;
  localparam int POOL_SIZE    = 40;

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  table_scoreboard  sb;
  bit               send_calm;
  bit               recv_calm;
  int unsigned      words_sent;
  logic [KEY_W-1:0] pool_text [POOL_SIZE];
  logic [LEN_W-1:0] pool_len  [POOL_SIZE];

  linear_probe_hash_table_unit uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Keys cluster around the end and start of the alphabet so that probes wrap.
  function automatic void random_key(output logic [KEY_W-1:0] text,
                                     output logic [LEN_W-1:0] len);
    logic [7:0] last;
    len  = ($urandom_range(0, 2) == 0) ? LEN_W'($urandom_range(1, 8))
                                       : LEN_W'($urandom_range(1, 3));
    text = {$urandom, $urandom} & ~({KEY_W{1'b1}} << (8 * len));
    last = CHAR_LOWER_A + 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 25)
                                                          : $urandom_range(22, 29) % 26);
    if ($urandom_range(0, 3) == 0) last = last - CASE_OFFSET;
    text[8 * (len - 1) +: 8] = last;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [KEY_W-1:0] text,
                           input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] idx);
    req_word_t   w;
    int unsigned gap;
    w   = '{command: cmd, key_text: text, key_length: len, slot_index: idx};
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(w);
    words_sent++;
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = pick_wait(recv_calm);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      sb.check_result(rsp);
    end
  end

  initial begin
    int               ins_pct;
    int               del_pct;
    int               pick;
    int               c;
    int               k;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] text;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [7:0]       odd;
    sb         = new();
    words_sent = 0;
    send_calm  = 1'b0;
    recv_calm  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_READ,   {KEY_W{1'b1}}, 4'hF, 5'd0);
    send_word(CMD_READ,   64'h0, 4'h0, 5'd31);
    send_word(CMD_READ,   64'h0, 4'h1, 5'd26);
    send_word(CMD_LOOKUP, 64'h61, 4'd1, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h61, 4'd1, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h6162, 4'd2, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h41, 4'd1, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h7A, 4'd1, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h5A7A, 4'd2, IDX_W'($urandom));
    send_word(CMD_DELETE, 64'h6162, 4'd2, IDX_W'($urandom));
    send_word(CMD_LOOKUP, 64'h41, 4'd1, IDX_W'($urandom));
    send_word(CMD_READ,   64'h0, 4'h0, 5'd1);
    send_word(CMD_DELETE, 64'h6162, 4'd2, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h6162, 4'd2, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h7A80_FFEE_0102_0304, 4'd8, IDX_W'($urandom));
    send_word(CMD_READ,   64'h0, 4'h0, 5'd4);
    send_word(CMD_LOOKUP, 64'hDEAD_BEEF_CC7A_0000, 4'd3, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h1234_5678_997A_0000, 4'd3, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h61, 4'd0, IDX_W'($urandom));
    send_word(CMD_DELETE, 64'h61, 4'd9, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h40, 4'd1, IDX_W'($urandom));
    send_word(CMD_LOOKUP, 64'h5B, 4'd1, IDX_W'($urandom));
    send_word(CMD_INSERT, 64'h60, 4'd1, IDX_W'($urandom));
    send_word(CMD_DELETE, 64'h7B, 4'd1, IDX_W'($urandom));
    hold_until_drained();

    // Fill the table past its capacity, then churn it in phases of differing mix.
    for (int i = 0; i < POOL_SIZE; i++) random_key(pool_text[i], pool_len[i]);
    for (int i = 0; i < 32; i++) send_word(CMD_INSERT, pool_text[i], pool_len[i], IDX_W'($urandom));

    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       begin ins_pct = 70; del_pct = 15; end
        1:       begin ins_pct = 40; del_pct = 30; end
        2:       begin ins_pct = 15; del_pct = 60; end
        default: begin ins_pct = 20; del_pct = 20; end
      endcase
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) hold_until_drained();
      repeat (4) begin
        k = $urandom_range(0, POOL_SIZE - 1);
        random_key(pool_text[k], pool_len[k]);
      end
      repeat (64) begin
        pick = $urandom_range(0, 99);
        c    = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL_SIZE - 1);
        text = pool_text[k];
        len  = pool_len[k];
        idx  = IDX_W'($urandom);
        cmd  = (c < ins_pct) ? CMD_INSERT : (c < ins_pct + del_pct) ? CMD_DELETE : CMD_LOOKUP;
        if (pick < 10) begin
          cmd  = CMD_READ;
          text = {$urandom, $urandom};
          len  = LEN_W'($urandom);
          if ($urandom_range(0, 5) != 0) idx = IDX_W'($urandom_range(0, 25));
        end else if (pick < 18) begin
          case ($urandom_range(0, 2))
            0: len = '0;
            1: len = LEN_W'($urandom_range(9, 15));
            default: begin
              len = LEN_W'($urandom_range(1, 8));
              do odd = 8'($urandom);
              while ((odd >= CHAR_UPPER_A && odd <= CHAR_UPPER_Z) ||
                     (odd >= CHAR_LOWER_A && odd < CHAR_LOWER_A + ALPHABET));
              text[8 * (len - 1) +: 8] = odd;
            end
          endcase
        end else if (pick < 24) begin
          random_key(text, len);
        end
        if ($urandom_range(0, 1) == 1)
          text = text | ({$urandom, $urandom} & ({KEY_W{1'b1}} << (8 * len)));
        send_word(cmd, text, len, idx);
      end
    end

    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/lpht_pkg.sv
design/lpht_key_chk.sv
design/linear_probe_hash_table_unit.sv
bench/lpht_scoreboard_pkg.sv
bench/tb_linear_probe_hash_table_unit.sv
